// File: src/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int STAT_W = 2;

  localparam int IN_TDATA_W = ((KEY_W + TAG_W + 7) / 8) * 8;
  localparam int OUT_W = STAT_W + KEY_W + TAG_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

// File: src/spq_ctrl.sv
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output spq_pkg::cmd_t     cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign cmd.capture = s_tvalid && s_tready;
  assign cmd.exec = (state == ST_EXEC) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.capture) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_EXEC))
    else $error("capture not followed by exec state");

  a_exec_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!m_tvalid || m_tready))
    else $error("result overwritten while waiting");

  a_no_capture_in_exec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !cmd.capture)
    else $error("word taken while busy");

endmodule

// File: src/spq_dp.sv
module spq_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spq_pkg::cmd_t                        cmd,
  input  logic                                 in_action,
  input  logic [spq_pkg::KEY_W-1:0]            in_key,
  input  logic [spq_pkg::TAG_W-1:0]            in_tag,
  output logic [spq_pkg::OUT_TDATA_W-1:0]      result
);

  logic [spq_pkg::KEY_W-1:0] keys [spq_pkg::DEPTH];
  logic [spq_pkg::TAG_W-1:0] tags [spq_pkg::DEPTH];
  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;

  logic                      act;
  logic [spq_pkg::KEY_W-1:0] ikey;
  logic [spq_pkg::TAG_W-1:0] itag;
  logic [spq_pkg::DEPTH-1:0] le;
  logic [spq_pkg::DEPTH-1:0] le_next;

  logic                      full;
  logic                      empty;
  logic                      do_ins;
  logic                      do_rem;

  logic [spq_pkg::STAT_W-1:0] res_status;
  logic [spq_pkg::KEY_W-1:0]  res_key;
  logic [spq_pkg::TAG_W-1:0]  res_tag;
  logic [spq_pkg::CNT_W-1:0]  res_occ;

  assign full = (count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign empty = (count == '0);
  assign do_ins = cmd.exec && (act == spq_pkg::ACT_INSERT) && !full;
  assign do_rem = cmd.exec && (act == spq_pkg::ACT_REMOVE) && !empty;

  // per-entry compare against the incoming key
  genvar g;
  generate
    for (g = 0; g < spq_pkg::DEPTH; g++) begin : g_cmp
      assign le_next[g] = (spq_pkg::CNT_W'(g) < count) && (keys[g] <= in_key);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act <= in_action;
      ikey <= in_key;
      itag <= in_tag;
      le <= le_next;
    end
  end

  // insert: keep below slot, new word at slot, shift up above
  // remove: shift everything down by one
  generate
    for (g = 0; g < spq_pkg::DEPTH; g++) begin : g_entry
      always_ff @(posedge clk) begin
        if (do_ins) begin
          if (!le[g]) begin
            if (g == 0) begin
              keys[g] <= ikey;
              tags[g] <= itag;
            end else if (le[(g == 0) ? 0 : g - 1]) begin
              keys[g] <= ikey;
              tags[g] <= itag;
            end else begin
              keys[g] <= keys[(g == 0) ? 0 : g - 1];
              tags[g] <= tags[(g == 0) ? 0 : g - 1];
            end
          end
        end else if (do_rem) begin
          if (g < spq_pkg::DEPTH - 1) begin
            keys[g] <= keys[(g < spq_pkg::DEPTH - 1) ? g + 1 : g];
            tags[g] <= tags[(g < spq_pkg::DEPTH - 1) ? g + 1 : g];
          end
        end
      end
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + 1'b1;
    end else if (do_rem) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_occ <= count_next;
      res_key <= '0;
      res_tag <= '0;
      res_status <= spq_pkg::STAT_OK;
      if (act == spq_pkg::ACT_INSERT) begin
        if (full) res_status <= spq_pkg::STAT_FULL;
      end else if (empty) begin
        res_status <= spq_pkg::STAT_EMPTY;
      end else begin
        res_key <= keys[0];
        res_tag <= tags[0];
      end
    end
  end

  assign result = spq_pkg::OUT_TDATA_W'({res_occ, res_tag, res_key, res_status});

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
    else $error("occupancy beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_ins |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow queue");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    do_rem |=> (count == $past(count) - 1'b1))
    else $error("remove did not shrink queue");

endmodule

// File: src/sorted_priority_queue.sv
// Sorted priority queue of up to spq_pkg::DEPTH entries (key 32 bits, tag 16 bits),
// kept in ascending key order with equal keys leaving first in, first out. Each
// input word is an insert (s_tuser 0) or a remove of the head (s_tuser 1), and
// each gives exactly one result word with a status, the removed key and tag, and
// the occupancy after the operation. For an item, the new key is first compared against
// every stored entry in parallel and the result registered; then the entry registers
// are shifted and the output register loaded, which waits until the output register is
// free or being drained. A new word is taken only once the last one's result is loaded.
module sorted_priority_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // key [31:0], item_tag [47:32]
  input  logic [spq_pkg::IN_TDATA_W-1:0]     s_tdata,
  // action [0]
  input  logic [0:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status [1:0], out_key [33:2], out_tag [49:34], occupancy [54:50]
  output logic [spq_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  spq_pkg::cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  spq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_action (s_tuser[0]),
    .in_key    (s_tdata[spq_pkg::KEY_W-1:0]),
    .in_tag    (s_tdata[spq_pkg::KEY_W+spq_pkg::TAG_W-1:spq_pkg::KEY_W]),
    .result    (m_tdata)
  );

endmodule
